>>> sv/fmcs_pkg.sv
// ----------------------------------------------------------------------------
// fmcs_pkg
// shared types, constants and control structs of the filled circle span unit
// ----------------------------------------------------------------------------
package fmcs_pkg;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned OFS_BITS   = 4;
  localparam int unsigned DEC_BITS   = 8;
  localparam logic [OFS_BITS-1:0] MAX_RADIUS = OFS_BITS'(9);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic [OFS_BITS-1:0]          ofs_t;
  typedef logic signed [DEC_BITS-1:0]   dec_t;

  typedef struct packed {
    coord_t origin_x;
    coord_t origin_y;
    ofs_t   radius;
  } in_word_t;

  typedef struct packed {
    coord_t cx;
    coord_t cy;
    ofs_t   dx;
    ofs_t   dy;
    logic   last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PERIM,
    ST_FILL
  } fmcs_state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic fill_start;
    logic fill_dec;
    logic step;
    logic sel_perim;
  } fmcs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic y_lt_x;
    logic x_lt_y;
    logic k_eq_x;
  } fmcs_stat_t;

endpackage

>>> sv/fmcs_in_if.sv
// ----------------------------------------------------------------------------
// fmcs_in_if
// valid/ready channel carrying one circle request word
// ----------------------------------------------------------------------------
interface fmcs_in_if;
  import fmcs_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/fmcs_out_if.sv
// ----------------------------------------------------------------------------
// fmcs_out_if
// valid/ready channel carrying one offset pair word
// ----------------------------------------------------------------------------
interface fmcs_out_if;
  import fmcs_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> sv/fmcs_datapath.sv
// ----------------------------------------------------------------------------
// fmcs_datapath
// walk position, fill row and decision registers with the midpoint step logic
// ----------------------------------------------------------------------------
module fmcs_datapath (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  fmcs_pkg::fmcs_cmd_t  cmd_i,
  input  fmcs_pkg::in_word_t   req_i,
  output fmcs_pkg::fmcs_stat_t stat_o,
  output fmcs_pkg::coord_t     cx_o,
  output fmcs_pkg::coord_t     cy_o,
  output fmcs_pkg::ofs_t       dx_o,
  output fmcs_pkg::ofs_t       dy_o
);
  import fmcs_pkg::*;

  localparam int unsigned SUM_BITS = DEC_BITS + 2;

  coord_t cx_q, cx_d, cy_q, cy_d;
  ofs_t   x_q, x_d, y_q, y_d, k_q, k_d;
  dec_t   d_q, d_d;

  ofs_t                       r_sat;
  ofs_t                       x_nxt, y_nxt;
  logic signed [SUM_BITS-1:0] inc;
  logic signed [SUM_BITS-1:0] d_sum;

  always_comb begin
    r_sat = (req_i.radius > MAX_RADIUS) ? MAX_RADIUS : req_i.radius;
    x_nxt = x_q + ofs_t'(1);
    // decision below zero means east, otherwise south-east
    if (d_q < 0) begin
      y_nxt = y_q;
      inc   = $signed(SUM_BITS'({x_nxt, 1'b0})) + SUM_BITS'(3);
    end else begin
      y_nxt = y_q - ofs_t'(1);
      inc   = $signed(SUM_BITS'({x_nxt, 1'b0})) - $signed(SUM_BITS'({y_nxt, 1'b0}))
              - SUM_BITS'(5);
    end
    d_sum = SUM_BITS'(d_q) + inc;

    cx_d = cx_q;
    cy_d = cy_q;
    x_d  = x_q;
    y_d  = y_q;
    k_d  = k_q;
    d_d  = d_q;
    if (cmd_i.load) begin
      cx_d = req_i.origin_x;
      cy_d = req_i.origin_y;
      x_d  = '0;
      y_d  = r_sat;
      d_d  = dec_t'(1) - dec_t'({1'b0, r_sat});
    end
    if (cmd_i.step) begin
      x_d = x_nxt;
      y_d = y_nxt;
      d_d = d_sum[DEC_BITS-1:0];
    end
    if (cmd_i.fill_start) k_d = y_q;
    if (cmd_i.fill_dec)   k_d = k_q - ofs_t'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0;
      cy_q <= '0;
      x_q  <= '0;
      y_q  <= '0;
      k_q  <= '0;
      d_q  <= '0;
    end else begin
      cx_q <= cx_d;
      cy_q <= cy_d;
      x_q  <= x_d;
      y_q  <= y_d;
      k_q  <= k_d;
      d_q  <= d_d;
    end
  end

  assign stat_o.y_lt_x = (y_q < x_q);
  assign stat_o.x_lt_y = (x_q < y_q);
  assign stat_o.k_eq_x = (k_q == x_q);

  assign cx_o = cx_q;
  assign cy_o = cy_q;
  assign dx_o = x_q;
  assign dy_o = cmd_i.sel_perim ? y_q : k_q;

endmodule

>>> sv/fmcs_ctrl.sv
// ----------------------------------------------------------------------------
// fmcs_ctrl
// sequencer: perimeter pair, fill run, midpoint step, end of circle
// ----------------------------------------------------------------------------
module fmcs_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 last_o,
  input  fmcs_pkg::fmcs_stat_t stat_i,
  output fmcs_pkg::fmcs_cmd_t  cmd_o
);
  import fmcs_pkg::*;

  fmcs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    last_o      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_PERIM;
        end
      end
      ST_PERIM: begin
        out_valid_o     = 1'b1;
        cmd_o.sel_perim = 1'b1;
        // empty fill range only happens on the final position
        last_o          = stat_i.y_lt_x;
        if (out_ready_i) begin
          if (stat_i.y_lt_x) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.fill_start = 1'b1;
            state_d          = ST_FILL;
          end
        end
      end
      ST_FILL: begin
        out_valid_o = 1'b1;
        last_o      = stat_i.k_eq_x && !stat_i.x_lt_y;
        if (out_ready_i) begin
          if (!stat_i.k_eq_x) begin
            cmd_o.fill_dec = 1'b1;
          end else if (stat_i.x_lt_y) begin
            cmd_o.step = 1'b1;
            state_d    = ST_PERIM;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/filled_midpoint_circle_spans_unit.sv
// ----------------------------------------------------------------------------
// filled_midpoint_circle_spans_unit
// filled disc offset generator using the midpoint circle walk
// ----------------------------------------------------------------------------
// Each input word carries a circle center and a radius (radii above 9 are
// clamped to 9). The unit walks one octant with an integer midpoint decision
// and, for every walk position (x, y), sends the perimeter pair (x, y) and then
// the pairs (x, k) for k from y down to x, each with the center attached, so a
// mirroring plotter can fill the disc from eight-way symmetry. The final pair
// of a circle has last set. One word is handled at a time: the input is taken,
// then the walk sequencer sends one pair per cycle, while the output is not
// stalled, straight from its position registers. The input is ready again in
// the cycle after the last pair is taken.
// ----------------------------------------------------------------------------
module filled_midpoint_circle_spans_unit (
  input logic       clk_i,
  input logic       rst_ni,
  fmcs_in_if.sink   in_i,
  fmcs_out_if.source out_o
);
  import fmcs_pkg::*;

  fmcs_cmd_t  cmd;
  fmcs_stat_t stat;
  logic       last;

  // sequencer
  fmcs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .last_o      (last),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // walk registers and step arithmetic
  fmcs_datapath u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (in_i.data),
    .stat_o (stat),
    .cx_o   (out_o.data.cx),
    .cy_o   (out_o.data.cy),
    .dx_o   (out_o.data.dx),
    .dy_o   (out_o.data.dy)
  );

  assign out_o.data.last = last;

  // never taking a new circle while pairs are still pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !out_o.valid)
    else $error("input ready while offset word pending");

  // every circle opens with the pair on the vertical axis
  a_first_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (out_o.valid && out_o.data.dx == '0))
    else $error("first offset word of a circle has nonzero dx");

  // last word taken returns the unit to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && out_o.data.last) |=> in_i.ready)
    else $error("unit not idle after final offset word");

  // offsets stay within the clamped radius
  a_ofs_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.data.dx <= MAX_RADIUS && out_o.data.dy <= MAX_RADIUS))
    else $error("offset beyond maximum radius");

endmodule
